/* hw/rtl/lscf_pkg.sv */
package lscf_pkg;

	localparam int unsigned MODULUS_W   = 16;
	localparam int unsigned VALUE_W     = 15;
	localparam int unsigned BOUND_W     = 15;
	localparam int unsigned SEL_LEN_W   = 11;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam int unsigned MAX_DIMENSION_DEFAULT = 1024;

	localparam logic [MODULUS_W-1:0] MODULUS_RESET = MODULUS_W'(1601);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODULUS          = 2'd0,
		REG_SELECTION_BOUND  = 2'd1,
		REG_SELECTION_LENGTH = 2'd2,
		REG_MAX_SAMPLES      = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_SUB = 1'b0,
		OP_ADD = 1'b1
	} op_t;

	typedef struct packed {
		logic               operation;
		logic [VALUE_W-1:0] left_value;
		logic [VALUE_W-1:0] right_value;
		logic               is_last;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] combined_value;
		logic               end_of_sample;
		logic               keep;
		logic [COUNT_W-1:0] store_index;
		logic               full_res;
		logic [COUNT_W-1:0] rejected_total;
	} out_item_t;

endpackage

/* hw/rtl/lwe_sample_combine_filter.sv */
// Combines two LWE samples one coordinate pair per transfer.
// Input channel: in_valid/in_stall with in_data carrying the operation, one
// coordinate of each sample and is_last, which marks the z pair that closes
// the sample. Output channel: out_valid/out_stall with one result per input
// transfer, in order: the combined value modulo the modulus and, on the z
// result, the keep/full verdict, the store slot and the rejection count.
// An input transfer reaches its result through one input register, then the
// modular add, bound check and verdict feed the result register. Throughput is
// one item per cycle while the receiver does not stall; the single add/compare
// path between those two registers sets it.
// When the receiver stalls, the result register holds, the input register
// fills behind it and in_stall rises only once both are occupied.
// Reset empties both stages, clears position, kept and rejection counts,
// and loads the configuration defaults (modulus 1601, the rest zero).
// Configuration writes are taken on any cycle with cfg_write high and must
// only happen while no item is in flight.
module lwe_sample_combine_filter #(
	parameter int unsigned MAX_DIMENSION = lscf_pkg::MAX_DIMENSION_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  lscf_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output lscf_pkg::out_item_t                 out_data,
	input  logic                                cfg_write,
	input  logic [lscf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lscf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned POS_W = $clog2(MAX_DIMENSION + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_DIMENSION);

	localparam int unsigned MW = lscf_pkg::MODULUS_W;
	localparam int unsigned VW = lscf_pkg::VALUE_W;
	localparam int unsigned CW = lscf_pkg::COUNT_W;

	// Configuration registers
	logic [MW-1:0]                    modulus_q;
	logic [lscf_pkg::BOUND_W-1:0]     selection_bound_q;
	logic [lscf_pkg::SEL_LEN_W-1:0]   selection_length_q;
	logic [CW-1:0]                    max_samples_q;

	// Per-sample and running state
	logic [POS_W-1:0] position_q;
	logic             all_zero_q;
	logic             within_bound_q;
	logic [CW-1:0]    kept_count_q;
	logic [CW-1:0]    rejected_count_q;

	// Pipeline
	logic                valid_s1;
	lscf_pkg::in_item_t  item_s1;
	logic                valid_s2;
	lscf_pkg::out_item_t result_s2;

	logic advance_s2;
	logic advance_s1;

	logic [MW:0]      diff_wide;
	logic [MW-1:0]    raw_sum;
	logic [MW-1:0]    combined;
	logic [MW-1:0]    half_modulus;
	logic signed [MW+1:0] centred;
	logic signed [MW+1:0] bound_pos;
	logic signed [MW+1:0] bound_neg;
	logic             coord_in_bound;
	logic             in_window;
	logic             sample_passes;
	logic             room_left;
	lscf_pkg::out_item_t result_d;

	assign advance_s2 = valid_s1 && (!valid_s2 || !out_stall);
	assign advance_s1 = in_valid && !in_stall;
	assign in_stall   = valid_s1 && !(!valid_s2 || !out_stall);

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q          <= lscf_pkg::MODULUS_RESET;
			selection_bound_q  <= '0;
			selection_length_q <= '0;
			max_samples_q      <= '0;
		end else if (cfg_write) begin
			case (lscf_pkg::cfg_reg_t'(cfg_index))
				lscf_pkg::REG_MODULUS:          modulus_q <= cfg_data[MW-1:0];
				lscf_pkg::REG_SELECTION_BOUND:
					selection_bound_q <= cfg_data[lscf_pkg::BOUND_W-1:0];
				lscf_pkg::REG_SELECTION_LENGTH:
					selection_length_q <= cfg_data[lscf_pkg::SEL_LEN_W-1:0];
				lscf_pkg::REG_MAX_SAMPLES:      max_samples_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Modular combination with one conditional correction, in 16 bits.
	always_comb begin
		diff_wide = {2'b00, item_s1.left_value} + {1'b0, modulus_q}
			- {2'b00, item_s1.right_value};
		if (item_s1.operation == lscf_pkg::OP_ADD) begin
			raw_sum = {1'b0, item_s1.left_value} + {1'b0, item_s1.right_value};
		end else begin
			raw_sum = diff_wide[MW-1:0];
		end
		if (raw_sum >= modulus_q) begin
			combined = raw_sum - modulus_q;
		end else begin
			combined = raw_sum;
		end
	end

	// Centred reading: values at or above half the modulus count as negative.
	always_comb begin
		half_modulus = modulus_q >> 1;
		if (combined < half_modulus) begin
			centred = $signed({2'b00, combined});
		end else begin
			centred = $signed({2'b00, combined}) - $signed({2'b00, modulus_q});
		end
		bound_pos      = $signed({3'b000, selection_bound_q});
		bound_neg      = -bound_pos;
		coord_in_bound = !(centred > bound_pos || centred < bound_neg);
		in_window      = (position_q < POS_MAX)
			&& (lscf_pkg::SEL_LEN_W'(position_q) < selection_length_q);
	end

	always_comb begin
		sample_passes = !all_zero_q && within_bound_q;
		room_left     = kept_count_q < max_samples_q;

		result_d                = '0;
		result_d.combined_value = combined[VW-1:0];
		result_d.end_of_sample  = item_s1.is_last;
		result_d.rejected_total = rejected_count_q;
		if (item_s1.is_last) begin
			if (sample_passes) begin
				if (room_left) begin
					result_d.keep        = 1'b1;
					result_d.store_index = kept_count_q;
				end else begin
					result_d.full_res = 1'b1;
				end
			end else if (rejected_count_q != {CW{1'b1}}) begin
				result_d.rejected_total = rejected_count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q       <= '0;
			all_zero_q       <= 1'b1;
			within_bound_q   <= 1'b1;
			kept_count_q     <= '0;
			rejected_count_q <= '0;
		end else if (advance_s2) begin
			if (item_s1.is_last) begin
				position_q       <= '0;
				all_zero_q       <= 1'b1;
				within_bound_q   <= 1'b1;
				rejected_count_q <= result_d.rejected_total;
				if (result_d.keep) begin
					kept_count_q <= kept_count_q + CW'(1);
				end
			end else begin
				if (combined != '0) begin
					all_zero_q <= 1'b0;
				end
				if (in_window && !coord_in_bound) begin
					within_bound_q <= 1'b0;
				end
				if (position_q < POS_MAX) begin
					position_q <= position_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance_s2) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s2) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			item_s1 <= in_data;
		end
		if (advance_s2) begin
			result_s2 <= result_d;
		end
	end

endmodule

/* hw/rtl/lscf_checker.sv */
module lscf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input lscf_pkg::out_item_t out_data
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Coordinate results carry no verdict.
	a_coord_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.end_of_sample |->
			!out_data.keep && !out_data.full_res && out_data.store_index == '0)
		else $error("verdict on a coordinate result");

	// A sample is either kept or dropped as full, never both.
	a_keep_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.keep |-> !out_data.full_res)
		else $error("kept and full at once");

	// Nothing is offered while reset is applied.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("pipeline not empty in reset");

endmodule

bind lwe_sample_combine_filter lscf_checker u_lscf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* tb/lwe_sample_combine_filter_test.sv */
module lwe_sample_combine_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_DIM     = lscf_pkg::MAX_DIMENSION_DEFAULT;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 62;

	typedef struct {
		logic [31:0] q;
		logic [31:0] bound;
		logic [31:0] window;
		logic [31:0] cap;
	} reg_set_t;

	typedef struct {
		int               setting;
		lscf_pkg::op_t    op;
		int unsigned      lhs;
		int unsigned      rhs;
		bit               last;
		bit               fixed;
		int unsigned      value;
		bit               keep;
		bit               full;
		int unsigned      rejected;
	} table_row_t;

	typedef struct {
		bit                  fixed;
		lscf_pkg::out_item_t want;
	} typed_result_t;

	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b1;
	logic                                 in_valid  = 1'b0;
	logic                                 in_stall;
	lscf_pkg::in_item_t                   in_data   = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	lscf_pkg::out_item_t                  out_data;
	logic                                 cfg_write = 1'b0;
	logic [lscf_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [lscf_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

	lwe_sample_combine_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies and running state of the combiner as the checker sees them.
	logic [lscf_pkg::MODULUS_W-1:0] q_reg      = lscf_pkg::MODULUS_RESET;
	logic [lscf_pkg::BOUND_W-1:0]   bound_reg  = '0;
	logic [lscf_pkg::SEL_LEN_W-1:0] window_reg = '0;
	logic [lscf_pkg::COUNT_W-1:0]   cap_reg    = '0;
	logic [lscf_pkg::SEL_LEN_W-1:0] coord_pos  = '0;
	bit                             all_zero   = 1'b1;
	bit                             bound_ok   = 1'b1;
	logic [lscf_pkg::COUNT_W-1:0]   kept_n     = '0;
	logic [lscf_pkg::COUNT_W-1:0]   rejected_n = '0;

	lscf_pkg::out_item_t combined_q [$];
	typed_result_t       table_q [$];

	int unsigned errors      = 0;
	int unsigned items_sent  = 0;
	int unsigned results_in  = 0;
	int unsigned samples_end = 0;
	int unsigned kept_seen   = 0;
	int unsigned full_seen   = 0;
	int unsigned quiet       = 0;
	int unsigned stall_left  = 0;
	bit          sender_idles    = 1'b1;
	bit          receiver_stalls = 1'b1;

	reg_set_t presets [3] = '{
		'{32768, 16384, 1024, 32'hFFFF_FFFF},
		'{16, 3, 2, 32'hFFFF_FFFF},
		'{2, 0, 0, 0}
	};

	// Typed rows only use the reset registers, where nothing can be kept.
	table_row_t directed_rows [23] = '{
		'{-1, lscf_pkg::OP_SUB, 0, 0, 1, 1, 0, 0, 0, 1},
		'{-1, lscf_pkg::OP_ADD, 5, 7, 0, 1, 12, 0, 0, 1},
		'{-1, lscf_pkg::OP_SUB, 10, 3, 1, 1, 7, 0, 1, 1},
		'{-1, lscf_pkg::OP_ADD, 32767, 32767, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_SUB, 0, 32767, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_SUB, 1600, 1600, 1, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 0, 0, 0, 1, 0, 0, 0, 1},
		'{-1, lscf_pkg::OP_SUB, 1600, 1600, 1, 1, 0, 0, 0, 2},
		'{0, lscf_pkg::OP_SUB, 0, 32767, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 32767, 32767, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 16384, 0, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_SUB, 32767, 0, 1, 0, 0, 0, 0, 0},
		'{1, lscf_pkg::OP_ADD, 2, 1, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_SUB, 0, 4, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 1, 1, 1, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 1, 0, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_SUB, 0, 9, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 0, 0, 1, 0, 0, 0, 0, 0},
		'{2, lscf_pkg::OP_ADD, 1, 1, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_ADD, 32767, 0, 0, 0, 0, 0, 0, 0},
		'{-1, lscf_pkg::OP_SUB, 1, 1, 1, 0, 0, 0, 0, 0}
	};

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report($sformatf("result %0d %s is %0d, expected %0d", results_in, name, got, want));
		end
	endtask

	function automatic lscf_pkg::out_item_t combine_step(lscf_pkg::in_item_t it);
		lscf_pkg::out_item_t res;
		int unsigned         sum16;
		int                  centred;
		res = '0;
		if (it.operation == lscf_pkg::OP_ADD) begin
			sum16 = (32'(it.left_value) + 32'(it.right_value)) & 32'hFFFF;
		end else begin
			sum16 = (32'(it.left_value) + 32'(q_reg) - 32'(it.right_value)) & 32'hFFFF;
		end
		if (sum16 >= 32'(q_reg)) begin
			sum16 = (sum16 - 32'(q_reg)) & 32'hFFFF;
		end
		res.combined_value = sum16[lscf_pkg::VALUE_W-1:0];
		res.end_of_sample  = it.is_last;
		if (!it.is_last) begin
			if (sum16 != 0) begin
				all_zero = 1'b0;
			end
			// Values at or above half the modulus count as negative.
			if (coord_pos < MAX_DIM && coord_pos < window_reg) begin
				centred = (sum16 < 32'(q_reg >> 1)) ? int'(sum16) : int'(sum16) - int'(q_reg);
				if (centred > int'(bound_reg) || centred < -int'(bound_reg)) begin
					bound_ok = 1'b0;
				end
			end
			if (coord_pos < MAX_DIM) begin
				coord_pos++;
			end
		end else begin
			if (!all_zero && bound_ok) begin
				if (kept_n < cap_reg) begin
					res.keep        = 1'b1;
					res.store_index = kept_n;
					kept_n++;
				end else begin
					res.full_res = 1'b1;
				end
			end else if (rejected_n != '1) begin
				rejected_n++;
			end
			coord_pos = '0;
			all_zero  = 1'b1;
			bound_ok  = 1'b1;
		end
		res.rejected_total = rejected_n;
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		lscf_pkg::out_item_t want;
		typed_result_t       tag;
		if (in_valid && !in_stall) begin
			want = combine_step(in_data);
			tag  = table_q.pop_front();
			if (tag.fixed) begin
				want = tag.want;
			end
			combined_q.push_back(want);
		end
		if (out_valid && !out_stall) begin
			results_in++;
			if (combined_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results_in));
			end else begin
				want = combined_q.pop_front();
				check_field("combined_value", 32'(out_data.combined_value),
					32'(want.combined_value));
				check_field("end_of_sample", 32'(out_data.end_of_sample),
					32'(want.end_of_sample));
				check_field("keep", 32'(out_data.keep), 32'(want.keep));
				check_field("store_index", out_data.store_index, want.store_index);
				check_field("full_res", 32'(out_data.full_res), 32'(want.full_res));
				check_field("rejected_total", out_data.rejected_total, want.rejected_total);
				samples_end += 32'(want.end_of_sample);
				kept_seen   += 32'(want.keep);
				full_seen   += 32'(want.full_res);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (receiver_stalls && $urandom_range(0, 6) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(lscf_pkg::in_item_t it, bit fixed, lscf_pkg::out_item_t want);
		table_q.push_back('{fixed, want});
		if (sender_idles && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (combined_q.size() != 0);
	endtask

	task automatic load_config(logic [31:0] q, logic [31:0] b, logic [31:0] w, logic [31:0] c);
		lscf_pkg::cfg_reg_t reg_sel;
		reg_sel = reg_sel.first();
		repeat (reg_sel.num()) begin
			cfg_write <= 1'b1;
			cfg_index <= reg_sel;
			case (reg_sel)
				lscf_pkg::REG_MODULUS: begin
					cfg_data <= q;
					q_reg = q[lscf_pkg::MODULUS_W-1:0];
				end
				lscf_pkg::REG_SELECTION_BOUND: begin
					cfg_data <= b;
					bound_reg = b[lscf_pkg::BOUND_W-1:0];
				end
				lscf_pkg::REG_SELECTION_LENGTH: begin
					cfg_data <= w;
					window_reg = w[lscf_pkg::SEL_LEN_W-1:0];
				end
				lscf_pkg::REG_MAX_SAMPLES: begin
					cfg_data <= c;
					cap_reg = c;
				end
				default: ;
			endcase
			@(posedge clk);
			reg_sel = reg_sel.next();
		end
		cfg_write <= 1'b0;
	endtask

	// Coordinates below zero_upto combine to zero; the rest mostly land near zero
	// around the bound edge, with some fully random pairs. The z pair is random.
	task automatic send_sample(int unsigned n_coords, int unsigned zero_upto);
		lscf_pkg::in_item_t it;
		int unsigned        q;
		int unsigned        tgt;
		int unsigned        delta;
		int unsigned        mode;
		q = 32'(q_reg);
		for (int unsigned i = 0; i <= n_coords; i++) begin
			it.operation = 1'($urandom_range(0, 1));
			it.is_last   = (i == n_coords);
			mode         = $urandom_range(0, 99);
			if (it.is_last || (i >= zero_upto && mode < 15)) begin
				it.left_value  = lscf_pkg::VALUE_W'($urandom);
				it.right_value = lscf_pkg::VALUE_W'($urandom);
			end else begin
				if (i < zero_upto || mode < 30) begin
					tgt = 0;
				end else begin
					delta = $urandom_range(0, 32'(bound_reg) + 1) % q;
					tgt   = ($urandom_range(0, 1) && delta != 0) ? q - delta : delta;
				end
				it.left_value = lscf_pkg::VALUE_W'($urandom_range(0, q - 1));
				if (it.operation == lscf_pkg::OP_SUB) begin
					it.right_value = lscf_pkg::VALUE_W'((32'(it.left_value) + q - tgt) % q);
				end else begin
					it.right_value = lscf_pkg::VALUE_W'((tgt + q - 32'(it.left_value)) % q);
				end
			end
			send_item(it, 1'b0, '0);
		end
	endtask

	initial begin
		lscf_pkg::in_item_t  it;
		lscf_pkg::out_item_t want;
		int unsigned q;
		int unsigned b;
		int unsigned w;
		int unsigned c;
		int unsigned phase_end;
		int unsigned pick;
		int unsigned n;

		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].setting >= 0) begin
				wait_drained();
				load_config(presets[directed_rows[k].setting].q,
					presets[directed_rows[k].setting].bound,
					presets[directed_rows[k].setting].window,
					presets[directed_rows[k].setting].cap);
			end
			it.operation        = directed_rows[k].op;
			it.left_value       = lscf_pkg::VALUE_W'(directed_rows[k].lhs);
			it.right_value      = lscf_pkg::VALUE_W'(directed_rows[k].rhs);
			it.is_last          = directed_rows[k].last;
			want.combined_value = lscf_pkg::VALUE_W'(directed_rows[k].value);
			want.end_of_sample  = directed_rows[k].last;
			want.keep           = directed_rows[k].keep;
			want.store_index    = '0;
			want.full_res       = directed_rows[k].full;
			want.rejected_total = directed_rows[k].rejected;
			send_item(it, directed_rows[k].fixed, want);
		end

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case ($urandom_range(0, 4))
				0:       q = 2;
				1:       q = 32768;
				2:       q = $urandom_range(2, 300);
				default: q = $urandom_range(2, 32768);
			endcase
			case ($urandom_range(0, 3))
				0:       b = 0;
				1:       b = 16384;
				default: b = $urandom_range(0, (q / 2 < 16384) ? q / 2 + 1 : 16384);
			endcase
			case ($urandom_range(0, 3))
				0:       w = 0;
				1:       w = 1024;
				2:       w = $urandom_range(0, 1024);
				default: w = $urandom_range(1, 12);
			endcase
			case ($urandom_range(0, 2))
				0:       c = kept_n;
				1:       c = 32'hFFFF_FFFF;
				default: c = kept_n + $urandom_range(1, 6);
			endcase
			load_config(q, b, w, c);
			sender_idles    = (ph != 3 && ph + 1 < PHASES);
			receiver_stalls = sender_idles;
			phase_end       = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					send_sample(0, 0);
				end else if (pick < 3) begin
					n = $urandom_range(1, 8);
					send_sample(n, n);
				end else begin
					send_sample($urandom_range(1, 12), 0);
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d coordinate and z transfers, %0d results checked over %0d samples.",
			items_sent, results_in, samples_end);
		$display("Samples kept: %0d, dropped on a full store: %0d, rejected: %0d.",
			kept_seen, full_seen, rejected_n);
		if (errors == 0 && combined_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
